[sv/slot_free_list_allocator_top_macros.svh]
// Assertion macros shared by the slot allocator RTL.
// Needs a signal named clock and a signal named reset in the using module.
`ifndef SLOT_FREE_LIST_ALLOCATOR_TOP_MACROS_SVH
`define SLOT_FREE_LIST_ALLOCATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define SFLA_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// antecedent implies consequent in the next cycle
`define SFLA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SFLA_ASSERT_SAME(lbl, ante, cons, msg)
`define SFLA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[sv/sfla_pkg.sv]
// Shared widths, codes and types of the slot allocator.
// No dependencies.
package sfla_pkg;

   localparam int MAX_SLOTS  = 1024;
   localparam int SLOT_W     = $clog2(MAX_SLOTS);
   localparam int COUNT_W    = $clog2(MAX_SLOTS + 1);
   localparam int LINK_W     = COUNT_W;
   localparam int STRIDE_W   = 15;
   localparam int UNIT_W     = STRIDE_W - 6 + 1;
   localparam int OFFSET_W   = 24;
   localparam int TOTAL_W    = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 15;

   // result status codes
   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_NO_FREE     = 2'd1;
   localparam logic [1:0] STATUS_BAD_RELEASE = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_COUNT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_STRIDE = 2'd1;

   // one slot entry: used mark plus link to the next free slot
   typedef struct packed {
      logic              used;
      logic [LINK_W-1:0] link;
   } slot_word_type;

   // configuration seen by the list controller
   typedef struct packed {
      logic               rebuild;
      logic [COUNT_W-1:0] rebuild_count;
      logic [COUNT_W-1:0] slot_count;
      logic [UNIT_W-1:0]  stride_units;
   } cfg_type;

   // one result beat
   typedef struct packed {
      logic                valid;
      logic [1:0]          status;
      logic [SLOT_W-1:0]   granted_slot;
      logic [OFFSET_W-1:0] slot_offset;
      logic [COUNT_W-1:0]  free_slots;
      logic [COUNT_W-1:0]  peak_used;
      logic [TOTAL_W-1:0]  overflow_total;
      logic [TOTAL_W-1:0]  acquire_total;
      logic [TOTAL_W-1:0]  release_total;
      logic [TOTAL_W-1:0]  usage_version;
   } rsp_type;

endpackage

[sv/slot_free_list_allocator_top.sv]
// Slot allocator top level: configuration registers and the list controller.
// Depends on sfla_pkg, sfla_list_ctrl.
//
// Use:
//  Request: raise start with req_mode (0 acquire, 1 release) and
//  req_released_slot; the beat is taken at an edge where busy is low.
//  Result: one beat per request, shown for one cycle with rsp_valid high.
//  The receiver cannot stall; every result must be taken when shown.
//  Timing: the accept edge moves the controller to its execute state,
//  whose decisions are registered into the result beat on the ports.
//  Requests do not overlap: busy stays high while the slot memory read
//  is followed by the write back of the same entry.
//  Configuration: csr_index 0 writes slot_count (clamped to 1..1024) and
//  restarts the free list in order with all counters cleared; index 1
//  writes the slot stride, rounded up to a multiple of 64. Other indexes
//  are ignored. Writes go while no request is in flight.
//  Reset: 1024 slots, stride 64, all slots free, counters zero. There is
//  no clearing pass; a fresh-slot mark stands in for the memory contents.
module slot_free_list_allocator_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_mode,
   input  logic [sfla_pkg::SLOT_W-1:0]        req_released_slot,
   output logic                               rsp_valid,
   output logic [1:0]                         rsp_status,
   output logic [sfla_pkg::SLOT_W-1:0]        rsp_granted_slot,
   output logic [sfla_pkg::OFFSET_W-1:0]      rsp_slot_offset,
   output logic [sfla_pkg::COUNT_W-1:0]       rsp_free_slots,
   output logic [sfla_pkg::COUNT_W-1:0]       rsp_peak_used,
   output logic [sfla_pkg::TOTAL_W-1:0]       rsp_overflow_total,
   output logic [sfla_pkg::TOTAL_W-1:0]       rsp_acquire_total,
   output logic [sfla_pkg::TOTAL_W-1:0]       rsp_release_total,
   output logic [sfla_pkg::TOTAL_W-1:0]       rsp_usage_version,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [sfla_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sfla_pkg::CSR_DATA_W-1:0]    csr_data
);

   logic [sfla_pkg::COUNT_W-1:0] slot_count_ff, slot_count_in;
   logic [sfla_pkg::UNIT_W-1:0]  units_ff, units_in;
   logic [sfla_pkg::COUNT_W-1:0] count_req;
   logic [sfla_pkg::COUNT_W-1:0] count_clamped;
   logic                         csr_write;
   sfla_pkg::cfg_type            cfg;
   sfla_pkg::rsp_type            rsp;

   assign csr_ready = !busy;
   assign csr_write = csr_valid && csr_ready;

   // clamp the slot count write to 1..MAX_SLOTS
   assign count_req = csr_data[sfla_pkg::COUNT_W-1:0];
   always_comb begin
      if (count_req == '0) begin
         count_clamped = sfla_pkg::COUNT_W'(1);
      end else if (count_req > sfla_pkg::COUNT_W'(sfla_pkg::MAX_SLOTS)) begin
         count_clamped = sfla_pkg::COUNT_W'(sfla_pkg::MAX_SLOTS);
      end else begin
         count_clamped = count_req;
      end
   end

   // register decode; stride kept in 64-byte units, rounded up
   always_comb begin
      slot_count_in = slot_count_ff;
      units_in      = units_ff;
      if (csr_write) begin
         unique case (csr_index)
            sfla_pkg::CSR_SLOT_COUNT: slot_count_in = count_clamped;
            sfla_pkg::CSR_SLOT_STRIDE: begin
               units_in = sfla_pkg::UNIT_W'(csr_data[sfla_pkg::STRIDE_W-1:6])
                          + sfla_pkg::UNIT_W'(|csr_data[5:0]);
            end
            default: begin
               units_in = units_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff <= sfla_pkg::COUNT_W'(sfla_pkg::MAX_SLOTS);
         units_ff      <= sfla_pkg::UNIT_W'(1);
      end else begin
         slot_count_ff <= slot_count_in;
         units_ff      <= units_in;
      end
   end

   assign cfg.rebuild       = csr_write && (csr_index == sfla_pkg::CSR_SLOT_COUNT);
   assign cfg.rebuild_count = count_clamped;
   assign cfg.slot_count    = slot_count_ff;
   assign cfg.stride_units  = units_ff;

   sfla_list_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .start             (start),
      .busy              (busy),
      .req_mode          (req_mode),
      .req_released_slot (req_released_slot),
      .rsp               (rsp)
   );

   assign rsp_valid          = rsp.valid;
   assign rsp_status         = rsp.status;
   assign rsp_granted_slot   = rsp.granted_slot;
   assign rsp_slot_offset    = rsp.slot_offset;
   assign rsp_free_slots     = rsp.free_slots;
   assign rsp_peak_used      = rsp.peak_used;
   assign rsp_overflow_total = rsp.overflow_total;
   assign rsp_acquire_total  = rsp.acquire_total;
   assign rsp_release_total  = rsp.release_total;
   assign rsp_usage_version  = rsp.usage_version;

endmodule

[sv/sfla_slot_ram.sv]
// Slot entry memory: one write port, one read port, registered read data.
// Depends on sfla_pkg.
module sfla_slot_ram (
   input  logic                         clock,
   input  logic                         rd_en,
   input  logic [sfla_pkg::SLOT_W-1:0]  rd_addr,
   output sfla_pkg::slot_word_type      rd_data,
   input  logic                         wr_en,
   input  logic [sfla_pkg::SLOT_W-1:0]  wr_addr,
   input  sfla_pkg::slot_word_type      wr_data
);

   sfla_pkg::slot_word_type mem [sfla_pkg::MAX_SLOTS];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[sv/sfla_list_ctrl.sv]
// Free list controller: read-modify-write of slot entries, counters, result beat.
// Depends on sfla_pkg, sfla_slot_ram and the assertion macro header.
`include "slot_free_list_allocator_top_macros.svh"
module sfla_list_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   input  sfla_pkg::cfg_type                  cfg,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_mode,
   input  logic [sfla_pkg::SLOT_W-1:0]        req_released_slot,
   output sfla_pkg::rsp_type                  rsp
);

   typedef enum logic {IDLE, EXEC} state_type;

   state_type                         state_ff, state_in;
   logic                              mode_ff, mode_in;
   logic [sfla_pkg::SLOT_W-1:0]       rel_ff, rel_in;
   logic [sfla_pkg::LINK_W-1:0]       head_ff, head_in;
   // slots at or above fresh have not been handed out since the last rebuild
   logic [sfla_pkg::COUNT_W-1:0]      fresh_ff, fresh_in;
   logic [sfla_pkg::COUNT_W-1:0]      free_ff, free_in;
   logic [sfla_pkg::COUNT_W-1:0]      peak_ff, peak_in;
   logic [sfla_pkg::TOTAL_W-1:0]      ovf_ff, ovf_in;
   logic [sfla_pkg::TOTAL_W-1:0]      acq_ff, acq_in;
   logic [sfla_pkg::TOTAL_W-1:0]      rls_ff, rls_in;
   logic [sfla_pkg::TOTAL_W-1:0]      ver_ff, ver_in;
   sfla_pkg::rsp_type                 rsp_ff, rsp_in;

   logic                              rd_en;
   logic [sfla_pkg::SLOT_W-1:0]       rd_addr;
   sfla_pkg::slot_word_type           rd_data;
   logic                              wr_en;
   logic [sfla_pkg::SLOT_W-1:0]       wr_addr;
   sfla_pkg::slot_word_type           wr_data;

   logic                              acq_fail;
   logic                              rel_fail;
   logic                              head_fresh;
   logic [sfla_pkg::COUNT_W-1:0]      used_now;
   logic [2*sfla_pkg::UNIT_W-1:0]     prod;

   sfla_slot_ram u_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   assign busy = (state_ff == EXEC);

   // read issue on the accept beat
   assign rd_en   = (state_ff == IDLE) && start;
   assign rd_addr = req_mode ? req_released_slot : head_ff[sfla_pkg::SLOT_W-1:0];

   // decisions in the execute cycle
   assign acq_fail   = (free_ff == '0) || (head_ff >= sfla_pkg::LINK_W'(sfla_pkg::MAX_SLOTS));
   assign head_fresh = (head_ff == fresh_ff);
   assign rel_fail   = ({1'b0, rel_ff} >= cfg.slot_count) || ({1'b0, rel_ff} >= fresh_ff)
                       || !rd_data.used;
   assign prod       = sfla_pkg::UNIT_W'(head_ff[sfla_pkg::SLOT_W-1:0]) * cfg.stride_units;

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      rel_in   = rel_ff;
      head_in  = head_ff;
      fresh_in = fresh_ff;
      free_in  = free_ff;
      peak_in  = peak_ff;
      ovf_in   = ovf_ff;
      acq_in   = acq_ff;
      rls_in   = rls_ff;
      ver_in   = ver_ff;
      wr_en    = 1'b0;
      wr_addr  = rel_ff;
      wr_data  = '{used: 1'b0, link: head_ff};
      used_now = '0;
      rsp_in   = rsp_ff;
      rsp_in.valid = 1'b0;

      unique case (state_ff)
         IDLE: begin
            if (start) begin
               mode_in  = req_mode;
               rel_in   = req_released_slot;
               state_in = EXEC;
            end
         end
         EXEC: begin
            state_in            = IDLE;
            rsp_in.valid        = 1'b1;
            rsp_in.status       = sfla_pkg::STATUS_OK;
            rsp_in.granted_slot = '0;
            rsp_in.slot_offset  = '0;
            if (!mode_ff) begin
               if (acq_fail) begin
                  ovf_in        = ovf_ff + 1'b1;
                  rsp_in.status = sfla_pkg::STATUS_NO_FREE;
               end else begin
                  // pop head: untouched slots link to the next index
                  if (head_fresh) begin
                     head_in  = head_ff + 1'b1;
                     fresh_in = fresh_ff + 1'b1;
                  end else begin
                     head_in  = rd_data.link;
                  end
                  wr_en    = 1'b1;
                  wr_addr  = head_ff[sfla_pkg::SLOT_W-1:0];
                  wr_data  = '{used: 1'b1, link: head_in};
                  free_in  = free_ff - 1'b1;
                  ver_in   = ver_ff + 1'b1;
                  acq_in   = acq_ff + 1'b1;
                  used_now = cfg.slot_count - free_in;
                  if (used_now > peak_ff) begin
                     peak_in = used_now;
                  end
                  rsp_in.granted_slot = head_ff[sfla_pkg::SLOT_W-1:0];
                  rsp_in.slot_offset  = {prod[sfla_pkg::OFFSET_W-7:0], 6'b0};
               end
            end else begin
               if (rel_fail) begin
                  rsp_in.status = sfla_pkg::STATUS_BAD_RELEASE;
               end else begin
                  // push released slot in front of the current head
                  wr_en   = 1'b1;
                  wr_addr = rel_ff;
                  wr_data = '{used: 1'b0, link: head_ff};
                  head_in = {1'b0, rel_ff};
                  free_in = free_ff + 1'b1;
                  ver_in  = ver_ff + 1'b1;
                  rls_in  = rls_ff + 1'b1;
               end
            end
            rsp_in.free_slots     = free_in;
            rsp_in.peak_used      = peak_in;
            rsp_in.overflow_total = ovf_in;
            rsp_in.acquire_total  = acq_in;
            rsp_in.release_total  = rls_in;
            rsp_in.usage_version  = ver_in;
         end
         default: begin
            state_in = IDLE;
         end
      endcase

      // slot count write restarts the list
      if (cfg.rebuild) begin
         head_in  = '0;
         fresh_in = '0;
         free_in  = cfg.rebuild_count;
         peak_in  = '0;
         ovf_in   = '0;
         acq_in   = '0;
         rls_in   = '0;
         ver_in   = '0;
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         head_ff      <= '0;
         fresh_ff     <= '0;
         free_ff      <= sfla_pkg::COUNT_W'(sfla_pkg::MAX_SLOTS);
         peak_ff      <= '0;
         ovf_ff       <= '0;
         acq_ff       <= '0;
         rls_ff       <= '0;
         ver_ff       <= '0;
         rsp_ff.valid <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fresh_ff     <= fresh_in;
         free_ff      <= free_in;
         peak_ff      <= peak_in;
         ovf_ff       <= ovf_in;
         acq_ff       <= acq_in;
         rls_ff       <= rls_in;
         ver_ff       <= ver_in;
         rsp_ff.valid <= rsp_in.valid;
      end
      mode_ff               <= mode_in;
      rel_ff                <= rel_in;
      rsp_ff.status         <= rsp_in.status;
      rsp_ff.granted_slot   <= rsp_in.granted_slot;
      rsp_ff.slot_offset    <= rsp_in.slot_offset;
      rsp_ff.free_slots     <= rsp_in.free_slots;
      rsp_ff.peak_used      <= rsp_in.peak_used;
      rsp_ff.overflow_total <= rsp_in.overflow_total;
      rsp_ff.acquire_total  <= rsp_in.acquire_total;
      rsp_ff.release_total  <= rsp_in.release_total;
      rsp_ff.usage_version  <= rsp_in.usage_version;
   end

   assign rsp = rsp_ff;

   // checks
   `SFLA_ASSERT_NEXT(a_beat_follows_exec, state_ff == EXEC, rsp_ff.valid,
      "result beat missing after execute cycle")
   `SFLA_ASSERT_NEXT(a_accept_goes_busy, (state_ff == IDLE) && start, state_ff == EXEC,
      "accepted request did not enter execute")
   `SFLA_ASSERT_SAME(a_fresh_bound, !cfg.rebuild, fresh_ff <= cfg.slot_count,
      "fresh mark beyond slot count")
   `SFLA_ASSERT_SAME(a_free_bound, !cfg.rebuild, free_ff <= cfg.slot_count,
      "free count beyond slot count")

endmodule
